// ===== sv/cdq_pkg.sv =====
// Shared types, codes and default sizes for the circular deque unit.
// No dependencies; imported by every other file of the block except cdq_ram.
`default_nettype none

package cdq_pkg;

    localparam int CDQ_DEPTH      = 128;
    localparam int CDQ_DATA_WIDTH = 32;

    // Command codes carried by an input transaction.
    localparam logic [2:0] CMD_QUERY      = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;
    localparam logic [2:0] CMD_REVERSE    = 3'd6;

    // Status codes returned with every result.
    localparam logic [1:0] STS_DONE       = 2'd0;
    localparam logic [1:0] STS_FULL       = 2'd1;
    localparam logic [1:0] STS_EMPTY      = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [7:0]         count;
        logic               is_empty;
        logic               is_full;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;   // apply the accepted command and launch the RAM reads
        logic load;   // capture the finished result into the output register
    } t_ctrl;

endpackage

`default_nettype wire

// ===== sv/circular_deque_unit.sv =====
// Top level of the circular deque unit: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl, cdq_datapath (and cdq_ram below it).
`default_nettype none

//  Channel   Direction  Handshake                    Payload
//  input     in         i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_ready    o_out_data (t_out_item)
//
//  In each transaction the accept cycle applies the command and launches both
//  end reads of the ring RAM; the execute state that follows turns the
//  registered RAM data into a result once the output register is free. The
//  synchronous RAM read is why the work is split this way. The input is ready
//  only in the idle state, so a new transaction is taken only after the last
//  one has loaded its result. Reset clears the pointers, count and direction
//  flag; the RAM needs no clearing pass as only slots written by pushes are ever read.
//  A stalled output holds the result; the execute state then waits and the
//  input stays not ready until the output register frees up.

module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH      = CDQ_DEPTH,
    parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    // Command bundle from the controller to the datapath.
    t_ctrl ctrl;

    // The controller owns the handshake and decides when the datapath steps
    // and when it loads the output register.
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (ctrl)
    );

    // The datapath keeps the deque state and the ring RAM, and forms results.
    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sv/cdq_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cdq_ctrl.sv =====
// Controller of the circular deque unit: handshake sequencing and output valid.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_ctrl     o_ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic step, load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign step        = i_in_valid && o_in_ready;
    // The result waits in the execute state until the output register is free.
    assign load        = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_ctrl      = '{step: step, load: load};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (step) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cdq_datapath.sv =====
// Datapath of the circular deque unit: end pointers, count, direction flag,
// ring RAM with write bypass, and the result register. Depends on cdq_pkg, cdq_ram.
`default_nettype none

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH      = CDQ_DEPTH,
    parameter int DATA_WIDTH = CDQ_DATA_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl     i_ctrl,
    input  wire t_in_item  i_in_data,
    output t_out_item      o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]         r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_rev, n_rev;
    logic [1:0]            r_status, n_status;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic                  r_byp_lo, r_byp_hi;
    t_out_item             r_out;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH+31:0] value_ext;
    logic                  full, empty, low;
    logic [DATA_WIDTH-1:0] rd_lo, rd_hi, lo_word, hi_word, fv_word, bv_word;
    logic [DATA_WIDTH+31:0] fv_ext, bv_ext;
    logic [CW+7:0]         count_ext;

    assign value_ext = {{DATA_WIDTH{1'b0}}, i_in_data.value};
    assign wdata     = value_ext[DATA_WIDTH-1:0];
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
        return (i >= AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = STS_DONE;
        we       = 1'b0;
        waddr    = '0;
        low      = 1'b0;
        case (i_in_data.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = STS_FULL;
                end else begin
                    low = (i_in_data.command == CMD_PUSH_FRONT) != r_rev;
                    we  = 1'b1;
                    if (empty) begin
                        n_head = '0;
                        n_tail = '0;
                        waddr  = '0;
                    end else if (low) begin
                        n_head = slot_dec(r_head);
                        waddr  = n_head;
                    end else begin
                        n_tail = slot_inc(r_tail);
                        waddr  = n_tail;
                    end
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    n_status = STS_EMPTY;
                end else begin
                    low = (i_in_data.command == CMD_POP_FRONT) != r_rev;
                    if (r_count == CW'(1)) begin
                        n_count = '0;
                        n_head  = '0;
                        n_tail  = '0;
                    end else begin
                        if (low) begin
                            n_head = slot_inc(r_head);
                        end else begin
                            n_tail = slot_dec(r_tail);
                        end
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
                n_head  = '0;
                n_tail  = '0;
                n_rev   = 1'b0;
            end
            CMD_REVERSE: begin
                if (!empty) begin
                    n_rev = !r_rev;
                end
            end
            default: begin
            end
        endcase
    end

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_ctrl.step && we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (i_ctrl.step),
        .i_raddr_a (n_head),
        .i_raddr_b (n_tail),
        .o_rdata_a (rd_lo),
        .o_rdata_b (rd_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_ctrl.step) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    // A read that hits the slot written in the same cycle sees old RAM data,
    // so the pushed word is kept aside and substituted.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_status <= n_status;
            r_wdata  <= wdata;
            r_byp_lo <= we && (waddr == n_head);
            r_byp_hi <= we && (waddr == n_tail);
        end
    end

    assign lo_word   = r_byp_lo ? r_wdata : rd_lo;
    assign hi_word   = r_byp_hi ? r_wdata : rd_hi;
    assign fv_word   = r_rev ? hi_word : lo_word;
    assign bv_word   = r_rev ? lo_word : hi_word;
    assign fv_ext    = {{32{fv_word[DATA_WIDTH-1]}}, fv_word};
    assign bv_ext    = {{32{bv_word[DATA_WIDTH-1]}}, bv_word};
    assign count_ext = {8'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_out.status      <= r_status;
            r_out.front_value <= empty ? 32'sd0 : fv_ext[31:0];
            r_out.back_value  <= empty ? 32'sd0 : bv_ext[31:0];
            r_out.count       <= count_ext[7:0];
            r_out.is_empty    <= empty;
            r_out.is_full     <= full;
        end
    end

    assign o_out_data = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count exceeds the ring depth");

    a_empty_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with end pointers away from slot zero");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctrl.step |=> ($stable(r_count) && $stable(r_head) && $stable(r_tail)
                          && $stable(r_rev)))
        else $error("deque state changed without an accepted command");

endmodule

`default_nettype wire
